### src/odo_pkg.sv
`timescale 1ns / 1ps

package odo_pkg;

    // table size and index width
    localparam int NUM_VEHICLES = 8;
    localparam int VIDX_W = (NUM_VEHICLES > 1) ? $clog2(NUM_VEHICLES) : 1;

    // field widths
    localparam int VEH_W   = 3;
    localparam int POS_W   = 32;
    localparam int STAMP_W = 48;
    localparam int YAW_W   = 16;
    localparam int KIND_W  = 2;
    localparam int SUM_W   = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SPEED_W    = 24;
    localparam int TURN_W     = 15;
    localparam int GAP_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP_US      = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd1311;
    localparam logic [TURN_W-1:0]  TURN_RESET  = 15'd50;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 24'd1000000;

    // interval kinds
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd3;

    // square root: 66-bit radicand, one result bit per step
    localparam int SQRT_STEPS = 33;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 3;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    // cycles from accepted request to result strobe
    localparam int ITEM_CYCLES = SQRT_STEPS + 10;

    localparam logic [31:0] US_PER_S = 32'd1000000;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_threshold;
        logic [TURN_W-1:0]  turn_threshold;
        logic [GAP_W-1:0]   max_gap_us;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic read;
        logic diff;
        logic mul_x;
        logic mul_y;
        logic add;
        logic sqrt;
        logic mul_s;
        logic mul_g;
        logic cmp;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
    } t_sts;

    // fold the vehicle number into the table by repeated subtraction
    function automatic logic [VEH_W-1:0] f_reduce_index(input logic [VEH_W-1:0] idx);
        logic [8:0] v;
        v = {6'b0, idx};
        for (int k = 0; k < 8; k++) begin
            if (v >= 9'(NUM_VEHICLES)) begin
                v = v - 9'(NUM_VEHICLES);
            end
        end
        return v[VEH_W-1:0];
    endfunction

endpackage

### src/odo_cfg.sv
`timescale 1ns / 1ps

module odo_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [odo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_cfg_ready,
    output odo_pkg::t_cfg                   o_cfg
);
    import odo_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_threshold <= SPEED_RESET;
            r_cfg.turn_threshold  <= TURN_RESET;
            r_cfg.max_gap_us      <= GAP_RESET;
        end else if (i_cfg_valid) begin
            // drop writes to unknown indexes
            unique case (i_cfg_index)
                REG_SPEED_THRESHOLD: r_cfg.speed_threshold <= i_cfg_data[SPEED_W-1:0];
                REG_TURN_THRESHOLD:  r_cfg.turn_threshold  <= i_cfg_data[TURN_W-1:0];
                REG_MAX_GAP_US:      r_cfg.max_gap_us      <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### src/odo_ctrl.sv
`timescale 1ns / 1ps

module odo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  odo_pkg::t_sts i_sts,
    output odo_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import odo_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_DIFF = 4'd2;
    localparam logic [3:0] ST_MULX = 4'd3;
    localparam logic [3:0] ST_MULY = 4'd4;
    localparam logic [3:0] ST_ADD  = 4'd5;
    localparam logic [3:0] ST_SQRT = 4'd6;
    localparam logic [3:0] ST_MULS = 4'd7;
    localparam logic [3:0] ST_MULG = 4'd8;
    localparam logic [3:0] ST_CMP  = 4'd9;
    localparam logic [3:0] ST_UPD  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_MULX;
            end
            ST_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = ST_MULY;
            end
            ST_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = ST_MULS;
                end
            end
            ST_MULS: begin
                o_cmd.mul_s = 1'b1;
                n_state     = ST_MULG;
            end
            ST_MULG: begin
                o_cmd.mul_g = 1'b1;
                n_state     = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/odo_dp.sv
`timescale 1ns / 1ps

module odo_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  odo_pkg::t_cmd                       i_cmd,
    output odo_pkg::t_sts                       o_sts,
    input  odo_pkg::t_cfg                       i_cfg,
    input  logic [odo_pkg::VEH_W-1:0]           i_robot_index,
    input  logic signed [odo_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [odo_pkg::POS_W-1:0]    i_pos_y,
    input  logic [odo_pkg::STAMP_W-1:0]         i_stamp_us,
    input  logic signed [odo_pkg::YAW_W-1:0]    i_yaw_rate,
    output logic                                o_done,
    output logic [odo_pkg::VEH_W-1:0]           o_vehicle,
    output logic [odo_pkg::KIND_W-1:0]          o_interval_kind,
    output logic [odo_pkg::SUM_W-1:0]           o_total_distance,
    output logic [odo_pkg::SUM_W-1:0]           o_total_moving_us,
    output logic [odo_pkg::SUM_W-1:0]           o_total_idle_us
);
    import odo_pkg::*;

    function automatic logic [SUM_W-1:0] f_sat_add(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // per-vehicle table; only the seen flags are reset
    logic [NUM_VEHICLES-1:0] r_tseen;
    logic [POS_W-1:0]        r_tx    [NUM_VEHICLES];
    logic [POS_W-1:0]        r_ty    [NUM_VEHICLES];
    logic [STAMP_W-1:0]      r_tstamp[NUM_VEHICLES];
    logic [SUM_W-1:0]        r_tdist [NUM_VEHICLES];
    logic [SUM_W-1:0]        r_tmov  [NUM_VEHICLES];
    logic [SUM_W-1:0]        r_tidle [NUM_VEHICLES];

    // request held for the whole item
    logic [VEH_W-1:0]   r_veh;
    logic [VIDX_W-1:0]  r_vidx;
    logic [POS_W-1:0]   r_x;
    logic [POS_W-1:0]   r_y;
    logic [STAMP_W-1:0] r_stamp;
    logic [YAW_W-1:0]   r_yaw;

    // entry copy
    logic               r_seen;
    logic [POS_W-1:0]   r_lx;
    logic [POS_W-1:0]   r_ly;
    logic [STAMP_W-1:0] r_lstamp;
    logic [SUM_W-1:0]   r_dsum;
    logic [SUM_W-1:0]   r_msum;
    logic [SUM_W-1:0]   r_isum;

    // working registers
    logic [POS_W-1:0]   r_dx;
    logic [POS_W-1:0]   r_dy;
    logic [STAMP_W-1:0] r_gap;
    logic               r_after;
    logic               r_in_range;
    logic               r_moving;
    logic [64:0]        r_prod;
    logic [64:0]        r_acc;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;

    logic [POS_W:0]     diff_x;
    logic [POS_W:0]     diff_y;
    logic [POS_W:0]     neg_x;
    logic [POS_W:0]     neg_y;
    logic [STAMP_W:0]   diff_t;
    logic [ROOT_W-1:0]  mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        mul_p;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic [YAW_W-1:0]   yaw_abs;
    logic [YAW_W-1:0]   yaw_neg;

    assign o_sts.sqrt_last = (r_cnt == '0);

    // signed differences, magnitudes below 2^32
    assign diff_x = {r_x[POS_W-1], r_x} - {r_lx[POS_W-1], r_lx};
    assign diff_y = {r_y[POS_W-1], r_y} - {r_ly[POS_W-1], r_ly};
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign diff_t = {1'b0, r_stamp} - {1'b0, r_lstamp};

    // one shared multiplier
    always_comb begin
        priority if (i_cmd.mul_y) begin
            mul_a = {1'b0, r_dy};
            mul_b = r_dy;
        end else if (i_cmd.mul_s) begin
            mul_a = r_root;
            mul_b = US_PER_S;
        end else if (i_cmd.mul_g) begin
            mul_a = ROOT_W'(i_cfg.speed_threshold);
            mul_b = 32'(r_gap[GAP_W-1:0]);
        end else begin
            mul_a = {1'b0, r_dx};
            mul_b = r_dx;
        end
    end
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // one result bit per step
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});

    assign yaw_neg = -r_yaw;
    assign yaw_abs = r_yaw[YAW_W-1] ? yaw_neg : r_yaw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_veh   <= f_reduce_index(i_robot_index);
            r_vidx  <= VIDX_W'(f_reduce_index(i_robot_index));
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_stamp <= i_stamp_us;
            r_yaw   <= i_yaw_rate;
        end
        if (i_cmd.read) begin
            r_seen   <= r_tseen[r_vidx];
            r_lx     <= r_tx[r_vidx];
            r_ly     <= r_ty[r_vidx];
            r_lstamp <= r_tstamp[r_vidx];
            r_dsum   <= r_tseen[r_vidx] ? r_tdist[r_vidx] : '0;
            r_msum   <= r_tseen[r_vidx] ? r_tmov[r_vidx]  : '0;
            r_isum   <= r_tseen[r_vidx] ? r_tidle[r_vidx] : '0;
        end
        if (i_cmd.diff) begin
            r_dx    <= diff_x[POS_W] ? neg_x[POS_W-1:0] : diff_x[POS_W-1:0];
            r_dy    <= diff_y[POS_W] ? neg_y[POS_W-1:0] : diff_y[POS_W-1:0];
            r_gap   <= diff_t[STAMP_W-1:0];
            r_after <= !diff_t[STAMP_W] && (diff_t[STAMP_W-1:0] != '0);
        end
        if (i_cmd.mul_x || i_cmd.mul_y || i_cmd.mul_s || i_cmd.mul_g) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_y || i_cmd.mul_g) begin
            r_acc <= r_prod;
        end
        if (i_cmd.add) begin
            r_rad      <= RAD_W'(r_acc) + RAD_W'(r_prod);
            r_rem      <= '0;
            r_root     <= '0;
            r_cnt      <= CNT_W'(SQRT_STEPS - 1);
            r_in_range <= r_after && (r_gap < STAMP_W'(i_cfg.max_gap_us));
        end
        if (i_cmd.sqrt) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.cmp) begin
            // r_acc holds step * 1e6, r_prod holds threshold * gap
            r_moving <= (r_acc >= r_prod) || (yaw_abs >= YAW_W'(i_cfg.turn_threshold));
        end
        if (i_cmd.upd) begin
            r_tx[r_vidx]     <= r_x;
            r_ty[r_vidx]     <= r_y;
            r_tstamp[r_vidx] <= r_stamp;
            o_vehicle        <= r_veh;
            if (r_seen && r_in_range) begin
                r_tdist[r_vidx]  <= f_sat_add(r_dsum, SUM_W'(r_root));
                o_total_distance <= f_sat_add(r_dsum, SUM_W'(r_root));
                if (r_moving) begin
                    r_tmov[r_vidx]    <= f_sat_add(r_msum, r_gap);
                    o_total_moving_us <= f_sat_add(r_msum, r_gap);
                    r_tidle[r_vidx]   <= r_isum;
                    o_total_idle_us   <= r_isum;
                    o_interval_kind   <= KIND_MOVING;
                end else begin
                    r_tmov[r_vidx]    <= r_msum;
                    o_total_moving_us <= r_msum;
                    r_tidle[r_vidx]   <= f_sat_add(r_isum, r_gap);
                    o_total_idle_us   <= f_sat_add(r_isum, r_gap);
                    o_interval_kind   <= KIND_IDLE;
                end
            end else begin
                r_tdist[r_vidx]   <= r_dsum;
                r_tmov[r_vidx]    <= r_msum;
                r_tidle[r_vidx]   <= r_isum;
                o_total_distance  <= r_dsum;
                o_total_moving_us <= r_msum;
                o_total_idle_us   <= r_isum;
                o_interval_kind   <= r_seen ? KIND_RANGE : KIND_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tseen <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.upd;
            if (i_cmd.upd) begin
                r_tseen[r_vidx] <= 1'b1;
            end
        end
    end

endmodule

### src/odometry_motion_accumulator.sv
`timescale 1ns / 1ps
// Per-vehicle odometry accumulator.
// Request channel: raise i_start with a sample (vehicle, Q16.16 position,
// microsecond stamp, yaw rate in mrad/s); the request is taken on a rising
// edge where i_start is high and o_busy is low. o_busy stays high while the
// request is worked on, so hold further samples until it falls.
// Result channel: o_done pulses for one cycle with the vehicle's totals and
// the interval kind. The receiver cannot stall, so capture the result in
// that cycle. One result follows every request.
// Sequencing: a new request can be taken in the strobe cycle, so the block
// works on one sample at a time. The 33-step bit-serial square root of
// dx^2 + dy^2 dominates; the remaining cycles are table read, differences,
// two squares and two threshold products on one shared 33x32 multiplier,
// the sum of the squares, compare and write-back.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// ready is always high. Write only while o_busy is low.
// Reset (synchronous, active low) marks every vehicle unseen, which reads its
// totals as zero, and restores the register defaults.
module odometry_motion_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [odo_pkg::VEH_W-1:0]           i_robot_index,
    input  logic signed [odo_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [odo_pkg::POS_W-1:0]    i_pos_y,
    input  logic [odo_pkg::STAMP_W-1:0]         i_stamp_us,
    input  logic signed [odo_pkg::YAW_W-1:0]    i_yaw_rate,
    output logic                                o_done,
    output logic [odo_pkg::VEH_W-1:0]           o_vehicle,
    output logic [odo_pkg::KIND_W-1:0]          o_interval_kind,
    output logic [odo_pkg::SUM_W-1:0]           o_total_distance,
    output logic [odo_pkg::SUM_W-1:0]           o_total_moving_us,
    output logic [odo_pkg::SUM_W-1:0]           o_total_idle_us,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [odo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import odo_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // threshold and gap registers
    odo_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // sequencer: steps one request through the datapath
    odo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // table, shared multiplier, square root and saturating sums
    odo_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg             (cfg),
        .i_robot_index     (i_robot_index),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_stamp_us        (i_stamp_us),
        .i_yaw_rate        (i_yaw_rate),
        .o_done            (o_done),
        .o_vehicle         (o_vehicle),
        .o_interval_kind   (o_interval_kind),
        .o_total_distance  (o_total_distance),
        .o_total_moving_us (o_total_moving_us),
        .o_total_idle_us   (o_total_idle_us)
    );

endmodule

### src/odo_checker.sv
`timescale 1ns / 1ps

module odo_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                o_busy,
    input  logic                                o_done,
    input  logic [odo_pkg::KIND_W-1:0]          o_interval_kind,
    input  logic [odo_pkg::SUM_W-1:0]           o_total_distance,
    input  logic [odo_pkg::SUM_W-1:0]           o_total_moving_us,
    input  logic [odo_pkg::SUM_W-1:0]           o_total_idle_us
);
    import odo_pkg::*;

    // an accepted request holds the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting a request");

    // the result strobe arrives a fixed time after acceptance
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(ITEM_CYCLES) o_done)
        else $error("result strobe missing at the expected cycle");

    // results appear only once the work is over
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while still busy");

    // a first sample carries empty totals
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_interval_kind == KIND_FIRST)) |->
        ((o_total_distance == '0) && (o_total_moving_us == '0)
         && (o_total_idle_us == '0)))
        else $error("first sample reported non-zero totals");

endmodule

bind odometry_motion_accumulator odo_checker u_odo_checker (.*);

### bench/odometry_motion_accumulator_tb.sv
`timescale 1ns / 1ps

module odometry_motion_accumulator_tb;

    import odo_pkg::*;

    // Index three has no register behind it: a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // Run cap in clock cycles. A slow but correct run (every request waiting
    // out the longest sender gap, plus the drains between phases) stays
    // below it.
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // One odometry request as presented on the input ports.
    typedef struct {
        logic [VEH_W-1:0]        robot_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [STAMP_W-1:0]      stamp_us;
        logic signed [YAW_W-1:0] yaw_rate;
    } t_odo_sample;

    // Totals reported for one vehicle after a request.
    typedef struct {
        logic [VEH_W-1:0]  vehicle;
        logic [KIND_W-1:0] kind;
        logic [SUM_W-1:0]  distance;
        logic [SUM_W-1:0]  moving_us;
        logic [SUM_W-1:0]  idle_us;
    } t_odo_totals;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic [VEH_W-1:0]         i_robot_index = '0;
    logic signed [POS_W-1:0]  i_pos_x = '0;
    logic signed [POS_W-1:0]  i_pos_y = '0;
    logic [STAMP_W-1:0]       i_stamp_us = '0;
    logic signed [YAW_W-1:0]  i_yaw_rate = '0;
    logic                     o_done;
    logic [VEH_W-1:0]         o_vehicle;
    logic [KIND_W-1:0]        o_interval_kind;
    logic [SUM_W-1:0]         o_total_distance;
    logic [SUM_W-1:0]         o_total_moving_us;
    logic [SUM_W-1:0]         o_total_idle_us;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    // Predicted register file and vehicle table, kept in step with the block.
    t_cfg                     model_cfg;
    logic                     veh_seen       [NUM_VEHICLES];
    logic signed [POS_W-1:0]  veh_last_x     [NUM_VEHICLES];
    logic signed [POS_W-1:0]  veh_last_y     [NUM_VEHICLES];
    logic [STAMP_W-1:0]       veh_last_stamp [NUM_VEHICLES];
    logic [SUM_W-1:0]         veh_distance   [NUM_VEHICLES];
    logic [SUM_W-1:0]         veh_moving     [NUM_VEHICLES];
    logic [SUM_W-1:0]         veh_idle       [NUM_VEHICLES];

    // Totals still owed by the block, oldest request first.
    t_odo_totals              expected_totals [$];
    t_odo_totals              head_totals;
    int unsigned              mismatch_count = 0;
    int unsigned              cycle_count = 0;

    odometry_motion_accumulator uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_robot_index     (i_robot_index),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_stamp_us        (i_stamp_us),
        .i_yaw_rate        (i_yaw_rate),
        .o_done            (o_done),
        .o_vehicle         (o_vehicle),
        .o_interval_kind   (o_interval_kind),
        .o_total_distance  (o_total_distance),
        .o_total_moving_us (o_total_moving_us),
        .o_total_idle_us   (o_total_idle_us),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Abandon the run if it hangs: a lost result or a stuck busy ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Restore the register defaults and mark every vehicle unseen.
    function automatic void reset_predictor();
        model_cfg.speed_threshold = SPEED_RESET;
        model_cfg.turn_threshold  = TURN_RESET;
        model_cfg.max_gap_us      = GAP_RESET;
        for (int v = 0; v < NUM_VEHICLES; v++) begin
            veh_seen[v]       = 1'b0;
            veh_last_x[v]     = '0;
            veh_last_y[v]     = '0;
            veh_last_stamp[v] = '0;
            veh_distance[v]   = '0;
            veh_moving[v]     = '0;
            veh_idle[v]       = '0;
        end
    endfunction

    // Magnitude of the difference of two signed positions; fits in 32 bits.
    function automatic logic [POS_W-1:0] pos_span(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0]        m;
        d = (POS_W+1)'(a) - (POS_W+1)'(b);
        m = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
        return m[POS_W-1:0];
    endfunction

    // Floored square root of a 66-bit radicand, one result bit at a time.
    function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] rad);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] c;
        logic [RAD_W-1:0]  sq;
        int                b;
        r = '0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            c  = r | (ROOT_W'(1) << b);
            sq = RAD_W'(c) * RAD_W'(c);
            if (sq <= rad) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // Apply one request to the predicted table and return the totals it reports.
    function automatic t_odo_totals predict_totals(input t_odo_sample s);
        int                v;
        logic [STAMP_W-1:0] gap;
        logic [POS_W-1:0]   dx;
        logic [POS_W-1:0]   dy;
        logic [ROOT_W-1:0]  step;
        logic [YAW_W:0]     yaw_mag;
        logic [63:0]        travel;
        logic [63:0]        budget;
        t_odo_totals        r;
        v      = int'(s.robot_index) % NUM_VEHICLES;
        r.kind = KIND_FIRST;
        if (veh_seen[v]) begin
            r.kind = KIND_RANGE;
            if (s.stamp_us > veh_last_stamp[v]) begin
                gap = s.stamp_us - veh_last_stamp[v];
                if (gap < STAMP_W'(model_cfg.max_gap_us)) begin
                    dx   = pos_span(s.pos_x, veh_last_x[v]);
                    dy   = pos_span(s.pos_y, veh_last_y[v]);
                    step = floor_root(RAD_W'(dx) * RAD_W'(dx) + RAD_W'(dy) * RAD_W'(dy));
                    veh_distance[v] = sat_add(veh_distance[v], SUM_W'(step));
                    // compare speed by cross multiplication, no division
                    travel  = 64'(step) * 64'(US_PER_S);
                    budget  = 64'(model_cfg.speed_threshold) * 64'(gap);
                    yaw_mag = s.yaw_rate[YAW_W-1] ?
                              (YAW_W+1)'(1 << YAW_W) - {1'b0, s.yaw_rate} :
                              {1'b0, s.yaw_rate};
                    if (travel >= budget || yaw_mag >= (YAW_W+1)'(model_cfg.turn_threshold)) begin
                        veh_moving[v] = sat_add(veh_moving[v], gap);
                        r.kind        = KIND_MOVING;
                    end else begin
                        veh_idle[v] = sat_add(veh_idle[v], gap);
                        r.kind      = KIND_IDLE;
                    end
                end
            end
        end
        veh_last_x[v]     = s.pos_x;
        veh_last_y[v]     = s.pos_y;
        veh_last_stamp[v] = s.stamp_us;
        veh_seen[v]       = 1'b1;
        r.vehicle   = VEH_W'(v);
        r.distance  = veh_distance[v];
        r.moving_us = veh_moving[v];
        r.idle_us   = veh_idle[v];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic t_odo_sample sample_of(input int idx,
                                              input logic [POS_W-1:0] x,
                                              input logic [POS_W-1:0] y,
                                              input logic [STAMP_W-1:0] stamp,
                                              input logic [YAW_W-1:0] yaw);
        t_odo_sample s;
        s.robot_index = VEH_W'(idx);
        s.pos_x       = x;
        s.pos_y       = y;
        s.stamp_us    = stamp;
        s.yaw_rate    = yaw;
        return s;
    endfunction

    // Present one request and hold it until taken. Leave i_start high on
    // return so that a back-to-back request can follow with i_start kept high.
    task automatic send_sample(input t_odo_sample s);
        @(negedge i_clk);
        i_robot_index <= s.robot_index;
        i_pos_x       <= s.pos_x;
        i_pos_y       <= s.pos_y;
        i_stamp_us    <= s.stamp_us;
        i_yaw_rate    <= s.yaw_rate;
        i_start       <= 1'b1;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        expected_totals.insert(expected_totals.size(), predict_totals(s));
    endtask

    // Send the next sample of a vehicle, relative to what the table holds:
    // the stamp advances by gap (negative steps back) and the position by dx, dy.
    task automatic send_follow(input int v, input longint gap,
                               input logic [POS_W-1:0] dx, input logic [POS_W-1:0] dy,
                               input logic [YAW_W-1:0] yaw);
        send_sample(sample_of(v, veh_last_x[v] + dx, veh_last_y[v] + dy,
                              veh_last_stamp[v] + STAMP_W'(gap), yaw));
    endtask

    // Drop i_start and hold it low for the given number of cycles.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 80) return $urandom_range(1, 8);
        if (roll < 95) return $urandom_range(9, 50);
        return $urandom_range(51, 300);
    endfunction

    // Hold requests off until every result has arrived, then let the block settle.
    task automatic wait_for_idle();
        pause_sender(1);
        while (expected_totals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ITEM_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (reg_index)
            REG_SPEED_THRESHOLD: model_cfg.speed_threshold = data[SPEED_W-1:0];
            REG_TURN_THRESHOLD:  model_cfg.turn_threshold  = data[TURN_W-1:0];
            REG_MAX_GAP_US:      model_cfg.max_gap_us      = data[GAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so take every strobe as it comes
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_totals.size() == 0) begin
                report_mismatch("result without request", 64'(o_vehicle), '0);
            end else begin
                head_totals = expected_totals.pop_front();
                if (o_vehicle !== head_totals.vehicle)
                    report_mismatch("vehicle", 64'(o_vehicle), 64'(head_totals.vehicle));
                if (o_interval_kind !== head_totals.kind)
                    report_mismatch("interval kind", 64'(o_interval_kind),
                                    64'(head_totals.kind));
                if (o_total_distance !== head_totals.distance)
                    report_mismatch("distance", 64'(o_total_distance),
                                    64'(head_totals.distance));
                if (o_total_moving_us !== head_totals.moving_us)
                    report_mismatch("moving time", 64'(o_total_moving_us),
                                    64'(head_totals.moving_us));
                if (o_total_idle_us !== head_totals.idle_us)
                    report_mismatch("idle time", 64'(o_total_idle_us),
                                    64'(head_totals.idle_us));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First sample of every vehicle: nothing accumulates. Use the position,
    // stamp and yaw extremes so the stored entries start at the corners.
    task automatic test_first_samples();
        send_sample(sample_of(0, '0, '0, '0, '0));
        pause_sender(sender_gap());
        send_sample(sample_of(1, 32'h8000_0000, 32'h8000_0000, 48'd1000, 16'h8000));
        pause_sender(sender_gap());
        send_sample(sample_of(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd2000, 16'h7FFF));
        for (int v = 3; v < NUM_VEHICLES - 1; v++) begin
            pause_sender(sender_gap());
            send_sample(sample_of(v, $urandom, $urandom, STAMP_W'(v) * 48'd1000,
                                  16'($urandom)));
        end
        pause_sender(sender_gap());
        // vehicle seven parks at the last stamp, so its next step wraps
        send_sample(sample_of(NUM_VEHICLES - 1, 32'h7FFF_FFFF, 32'h8000_0000,
                              {STAMP_W{1'b1}}, '0));
    endtask

    // Moving, idle and range kinds under the reset defaults, with the boundaries.
    task automatic test_interval_kinds();
        // speed boundary: 1311 * 50000 / 1e6 = 65.55, so 66 moves and 65 idles
        send_follow(0, 50000, 66, 0, '0);
        send_follow(0, 50000, 65, 0, '0);
        // yaw boundary at the turn threshold, both signs
        send_follow(0, 20000, 0, 0, 16'sd50);
        send_follow(0, 20000, 0, 0, -16'sd49);
        send_follow(0, 20000, 0, 0, -16'sd50);
        // last gap still counted, then the first one that is not
        send_follow(0, longint'(GAP_RESET) - 1, 3, 4, '0);
        send_follow(0, longint'(GAP_RESET), 3, 4, '0);
        // repeated stamp, then a stamp that steps back
        send_follow(0, 0, 7, 7, '0);
        send_follow(0, -5, 7, 7, '0);
        // widest step: both axes span the whole signed range
        send_follow(1, 1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
        send_follow(2, 1, 1, 1, 16'h7FFF);
        // stamp wraps to zero, which is not after the last one
        send_follow(NUM_VEHICLES - 1, 1, 0, 0, '0);
    endtask

    // Register extremes, masking to width and a write to the unused index.
    task automatic test_register_extremes();
        wait_for_idle();
        write_register(REG_SPEED_THRESHOLD, '0);
        write_register(REG_TURN_THRESHOLD, 24'hFF_FF00);
        write_register(REG_UNMAPPED, 24'($urandom));
        write_register(REG_MAX_GAP_US, 24'd1);
        // no gap is below one
        send_follow(3, 1, 5, 5, '0);
        wait_for_idle();
        write_register(REG_MAX_GAP_US, '0);
        send_follow(3, 100, 0, 0, '0);
        wait_for_idle();
        write_register(REG_SPEED_THRESHOLD, {CFG_DATA_W{1'b1}});
        write_register(REG_TURN_THRESHOLD, 24'(TURN_W'('1)));
        write_register(REG_MAX_GAP_US, {CFG_DATA_W{1'b1}});
        // the most negative yaw clears the largest turn threshold, 32766 does not
        send_follow(4, 16777214, 0, 0, 16'h8000);
        send_follow(4, 100, 1000, 0, 16'sd32766);
        send_follow(5, 16777215, 0, 0, '0);
        wait_for_idle();
        write_register(REG_TURN_THRESHOLD, '0);
        // a zero turn threshold counts every interval as moving
        send_follow(6, 10, 0, 0, '0);
    endtask

    // One random request: mostly well-formed tracks near the speed and turn
    // thresholds, some broken sequences and some raw noise.
    task automatic send_random_sample();
        int          v;
        int          roll;
        longint      gap;
        int unsigned hi;
        int unsigned span;
        logic [63:0] lim;
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        logic [YAW_W-1:0] yaw;
        v    = $urandom_range(0, NUM_VEHICLES - 1);
        roll = $urandom_range(0, 99);
        if (!veh_seen[v] || roll < 10) begin
            send_sample(sample_of(v, $urandom, $urandom, STAMP_W'({$urandom, $urandom}),
                                  16'($urandom)));
        end else if (roll < 20) begin
            // stamp repeated or stepping back, or a gap past the limit
            if (roll < 15) gap = -longint'($urandom_range(0, 2000));
            else gap = longint'(model_cfg.max_gap_us) + longint'($urandom_range(0, 2000));
            send_follow(v, gap, $urandom_range(0, 5000), $urandom_range(0, 5000),
                        16'($urandom));
        end else begin
            if (model_cfg.max_gap_us <= 1) begin
                gap = 1;
            end else begin
                hi   = model_cfg.max_gap_us - 1;
                roll = $urandom_range(0, 99);
                if (roll < 70) gap = longint'($urandom_range(1, (hi < 100000) ? hi : 100000));
                else if (roll < 85) gap = longint'(hi - $urandom_range(0, (hi > 4) ? 3 : hi - 1));
                else gap = longint'($urandom_range(1, hi));
            end
            // step length at the speed boundary for this gap; straddle it
            lim = (64'(model_cfg.speed_threshold) * 64'(gap)) / 64'(US_PER_S);
            if (lim > 64'h3FFF_FFFF) lim = 64'h3FFF_FFFF;
            span = $urandom_range(0, 32'(lim) * 2 + 3);
            if ($urandom_range(0, 19) == 0) begin
                dx = $urandom;
                dy = $urandom;
            end else begin
                dx = span;
                dy = $urandom_range(0, span / 4);
                if ($urandom_range(0, 1)) dx = -dx;
                if ($urandom_range(0, 1)) dy = -dy;
            end
            if (model_cfg.turn_threshold == 0 || $urandom_range(0, 99) < 35) begin
                yaw = 16'($urandom);
            end else begin
                span = $urandom_range(0, model_cfg.turn_threshold - 1);
                yaw  = $urandom_range(0, 1) ? 16'(-span) : 16'(span);
            end
            send_follow(v, gap, dx, dy, yaw);
        end
    endtask

    // Random traffic under one register setting. Run bursts without gaps,
    // and now and then hold the sender until the block has drained.
    task automatic test_random_traffic(input int count,
                                       input logic [CFG_DATA_W-1:0] speed,
                                       input logic [CFG_DATA_W-1:0] turn,
                                       input logic [CFG_DATA_W-1:0] max_gap);
        wait_for_idle();
        write_register(REG_SPEED_THRESHOLD, speed);
        write_register(REG_TURN_THRESHOLD, turn);
        write_register(REG_MAX_GAP_US, max_gap);
        for (int n = 0; n < count; n++) begin
            send_random_sample();
            if ($urandom_range(0, 39) == 0) wait_for_idle();
            else pause_sender(((n % 48) < 12) ? 0 : sender_gap());
        end
    endtask

    initial begin
        reset_predictor();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_samples();
        test_interval_kinds();
        test_register_extremes();
        test_random_traffic(120, 24'(SPEED_RESET), 24'(TURN_RESET), 24'(GAP_RESET));
        test_random_traffic(110, 24'($urandom_range(0, 4000)), 24'($urandom_range(0, 500)),
                            24'($urandom_range(20000, 2000000)));
        test_random_traffic(110, {CFG_DATA_W{1'b1}}, 24'(TURN_W'('1)), {CFG_DATA_W{1'b1}});
        test_random_traffic(110, 24'($urandom_range(0, 100000)), 24'($urandom_range(0, 200)),
                            24'($urandom_range(2, 5000)));

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### odometry_motion_accumulator.f
src/odo_pkg.sv
src/odo_cfg.sv
src/odo_ctrl.sv
src/odo_dp.sv
src/odometry_motion_accumulator.sv
src/odo_checker.sv
bench/odometry_motion_accumulator_tb.sv
